>>> hdl/aes_pkg.sv
// aes-128 package: s-box table, round helpers and key schedule step
// no dependencies
package aes_pkg;

    localparam int BlockWidth  = 128;
    localparam int KeyWidth    = 128;
    localparam int NumRounds   = 10;
    localparam int CfgAddrWidth = 4;
    localparam logic [CfgAddrWidth-1:0] AddrKeyHi = 4'h0;
    localparam logic [CfgAddrWidth-1:0] AddrKeyLo = 4'h8;

    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [7:0] byte_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic byte_t xtime(input byte_t a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k sits at bits 127-8k
    function automatic byte_t get_byte(input block_t s, input int k);
        get_byte = s[BlockWidth-1-8*k -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BlockWidth-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
        sub_shift = t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BlockWidth-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BlockWidth-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BlockWidth-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BlockWidth-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_columns = t;
    endfunction

    function automatic block_t next_key(input block_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

>>> hdl/aes_stream_if.sv
// valid/ready channel carrying one 128-bit block as two halves
// no dependencies
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_hi;
    logic [63:0] data_lo;

    modport source (output valid, output data_hi, output data_lo, input ready);
    modport sink (input valid, input data_hi, input data_lo, output ready);
endinterface

>>> hdl/aes128_block_encrypt.sv
// aes-128 encryption core: eleven-stage pipeline, round keys carried with each item
// depends on aes_pkg and aes_stream_if
//
// One block is accepted per clock while the pipe advances; it passes through stages 0 to 10
// in order. Stage 0 adds the cipher key; stages 1 to 10 each do one round and expand the
// round key that travels alongside the item, so a key write never disturbs blocks in
// flight. The whole pipe advances when the output register is empty or being taken, so
// a stall at the output holds every stage. Key registers are 64-bit at byte addresses
// 0 (key_hi) and 8 (key_lo).
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    aes_stream_if.sink              in_blk,
    aes_stream_if.source            out_blk
);

    logic [63:0] key_hi_reg;
    logic [63:0] key_lo_reg;
    logic        cfg_wr;

    block_t state_reg [NumRounds+1];
    block_t rkey_reg  [NumRounds];
    logic   valid_reg [NumRounds+1];
    logic   advance;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                AddrKeyHi: key_hi_reg <= pwdata;
                AddrKeyLo: key_lo_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            AddrKeyHi: prdata = key_hi_reg;
            AddrKeyLo: prdata = key_lo_reg;
            default:   prdata = '0;
        endcase
    end

    assign advance      = !valid_reg[NumRounds] || out_blk.ready;
    assign in_blk.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NumRounds; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_blk.valid;
            for (int i = 1; i <= NumRounds; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg[0] <= {in_blk.data_hi, in_blk.data_lo} ^ {key_hi_reg, key_lo_reg};
            rkey_reg[0]  <= {key_hi_reg, key_lo_reg};
            for (int i = 1; i <= NumRounds; i++)
            begin
                if (i < NumRounds)
                    rkey_reg[i] <= next_key(rkey_reg[i-1], RCON[i-1]);
                if (i == NumRounds)
                    state_reg[i] <= sub_shift(state_reg[i-1])
                                    ^ next_key(rkey_reg[i-1], RCON[i-1]);
                else
                    state_reg[i] <= mix_columns(sub_shift(state_reg[i-1]))
                                    ^ next_key(rkey_reg[i-1], RCON[i-1]);
            end
        end
    end

    assign out_blk.valid   = valid_reg[NumRounds];
    assign out_blk.data_hi = state_reg[NumRounds][127:64];
    assign out_blk.data_lo = state_reg[NumRounds][63:0];

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_blk.valid && !out_blk.ready |=> out_blk.valid && $stable(out_blk.data_hi)
            && $stable(out_blk.data_lo))
    else $error("held result changed");

    // an accepted block reaches the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_blk.valid && in_blk.ready |=> valid_reg[0])
    else $error("accepted item lost");

    // first-stage valid holds while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> valid_reg[0] == $past(valid_reg[0]))
    else $error("pipe moved under stall");

endmodule
